[hdl/slx_pkg.sv]
package slx_pkg;

  localparam int OFFSET_BITS_DEF     = 20;
  localparam int KEYWORD_MAX_LEN_DEF = 6;
  localparam int LINE_BITS           = 21;
  localparam int KIND_BITS           = 6;
  localparam int ERR_BITS            = 2;
  localparam int QUEUE_DEPTH         = 4;
  localparam int MAX_RESULTS         = 3;
  localparam int CNT_BITS            = 2;

  localparam logic [LINE_BITS-1:0] LINE_LIMIT = 21'd1048576;

  localparam logic [ERR_BITS-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_UNEXPECT = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_UNTERM   = 2'd2;
  localparam logic [ERR_BITS-1:0] ERR_DECIMAL  = 2'd3;

  localparam logic [KIND_BITS-1:0] K_ERROR   = 6'd0;
  localparam logic [KIND_BITS-1:0] K_NE      = 6'd8;
  localparam logic [KIND_BITS-1:0] K_NOT     = 6'd9;
  localparam logic [KIND_BITS-1:0] K_EQEQ    = 6'd17;
  localparam logic [KIND_BITS-1:0] K_ASSIGN  = 6'd18;
  localparam logic [KIND_BITS-1:0] K_LE      = 6'd21;
  localparam logic [KIND_BITS-1:0] K_LT      = 6'd22;
  localparam logic [KIND_BITS-1:0] K_GE      = 6'd23;
  localparam logic [KIND_BITS-1:0] K_GT      = 6'd24;
  localparam logic [KIND_BITS-1:0] K_BREAK   = 6'd7;
  localparam logic [KIND_BITS-1:0] K_STRING  = 6'd25;
  localparam logic [KIND_BITS-1:0] K_CSTRING = 6'd26;
  localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd27;
  localparam logic [KIND_BITS-1:0] K_INT     = 6'd28;
  localparam logic [KIND_BITS-1:0] K_DECIMAL = 6'd29;
  localparam logic [KIND_BITS-1:0] K_KW0     = 6'd30;

  localparam logic [6:0] KIND_NONE = 7'd64;

  localparam int NUM_KW = 11;
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h6E66, 64'h746375727473, 64'h6669, 64'h65736C65, 64'h65757274,
    64'h65736C6166, 64'h646E61, 64'h726F, 64'h726F66, 64'h656C696877,
    64'h726F78
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd6, 4'd2, 4'd4, 4'd4, 4'd5, 4'd3, 4'd2, 4'd3, 4'd5, 4'd3
  };

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] b);
    logic [6:0] k;
    case (b)
      "^": k = 7'd0;
      ".": k = 7'd1;
      "(": k = 7'd2;
      ")": k = 7'd3;
      "{": k = 7'd4;
      "}": k = 7'd5;
      ":": k = 7'd6;
      ",": k = 7'd10;
      "[": k = 7'd11;
      "]": k = 7'd12;
      "*": k = 7'd13;
      "/": k = 7'd14;
      "+": k = 7'd15;
      "-": k = 7'd16;
      "|": k = 7'd19;
      "&": k = 7'd20;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  // all eleven compares run side by side; first hit wins
  function automatic logic [KIND_BITS-1:0] kw_match(input logic [63:0] kbuf,
                                                    input logic [3:0] klen);
    logic [KIND_BITS-1:0] kind;
    logic hit;
    kind = K_IDENT;
    hit  = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!hit && KW_LEN[k] == klen && KW_TEXT[k] == kbuf) begin
        kind = K_KW0 + KIND_BITS'(k);
        hit  = 1'b1;
      end
    end
    return kind;
  endfunction

endpackage

[hdl/slx_front.sv]
module slx_front #(
  parameter int OFFSET_BITS     = slx_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = slx_pkg::KEYWORD_MAX_LEN_DEF,
  parameter int RW              = 6 + 2 * OFFSET_BITS + 1 + 21 + 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 acc,
  input  logic [7:0]                           src_byte,
  input  logic                                 eos,
  output logic                                 push,
  output logic [slx_pkg::CNT_BITS+3*RW-1:0]    push_data
);
  import slx_pkg::*;

  localparam int OB  = OFFSET_BITS;
  localparam int KLW = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int KBW = 8 * KEYWORD_MAX_LEN;
  localparam logic [OB:0] OFF_LIMIT = (OB+1)'(1) << OB;

  typedef enum logic [3:0] {
    M_IDLE, M_PENDOP, M_NLRUN, M_COMMENT, M_STRING, M_CSTRING,
    M_AFTERC, M_IDENT, M_NUMBER
  } mode_t;

  mode_t           mode, mode_next;
  logic [OB-1:0]   tstart, tstart_next;
  logic [OB:0]     boff, boff_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic            seendec, seendec_next;
  logic [KBW-1:0]  kbuf, kbuf_next;
  logic [KLW-1:0]  klen, klen_next;
  logic [7:0]      pend, pend_next;
  logic            halted, halted_next;

  logic [RW-1:0]   res [MAX_RESULTS];
  logic [CNT_BITS-1:0] n;

  function automatic logic [RW-1:0] make_res(input logic [KIND_BITS-1:0] kind,
                                             input logic [OB+1:0] st,
                                             input logic [OB+1:0] en,
                                             input logic [ERR_BITS-1:0] err,
                                             input logic [LINE_BITS-1:0] ln);
    logic [OB+1:0] len;
    len = (en > st) ? en - st : '0;
    return {err, ln, len[OB:0], st[OB-1:0], kind};
  endfunction

  function automatic logic [OB-1:0] clamp(input logic [OB+1:0] v);
    return (v[OB+1:OB] != 2'b00) ? {OB{1'b1}} : v[OB-1:0];
  endfunction

  function automatic logic [KIND_BITS-1:0] op_kind(input logic [7:0] op,
                                                   input logic two);
    logic [KIND_BITS-1:0] k;
    case (op)
      "!": k = two ? K_NE : K_NOT;
      "=": k = two ? K_EQEQ : K_ASSIGN;
      "<": k = two ? K_LE : K_LT;
      default: k = two ? K_GE : K_GT;
    endcase
    return k;
  endfunction

  always_comb begin
    logic [OB+1:0] off, off1, ts;
    logic consumed;
    logic [6:0] sk;
    logic [KIND_BITS-1:0] kk;

    mode_next    = mode;
    tstart_next  = tstart;
    boff_next    = boff;
    line_next    = line;
    seendec_next = seendec;
    kbuf_next    = kbuf;
    klen_next    = klen;
    pend_next    = pend;
    halted_next  = halted;
    for (int i = 0; i < MAX_RESULTS; i++) res[i] = '0;
    n        = '0;
    consumed = 1'b0;
    off  = {1'b0, boff};
    off1 = off + 1'b1;
    ts   = {2'b00, tstart};
    sk   = single_kind(src_byte);
    kk   = '0;

    if (halted) begin
      if (eos) begin
        mode_next = M_IDLE; tstart_next = '0; boff_next = '0;
        line_next = LINE_BITS'(1); seendec_next = 1'b0; kbuf_next = '0;
        klen_next = '0; pend_next = '0; halted_next = 1'b0;
      end
    end else begin
      case (mode)
        M_PENDOP: begin
          if (src_byte == "=") begin
            res[n] = make_res(op_kind(pend, 1'b1), ts, off1, ERR_NONE, line_next);
            consumed = 1'b1;
          end else begin
            res[n] = make_res(op_kind(pend, 1'b0), ts, ts + 1'b1, ERR_NONE, line_next);
          end
          n = n + 1'b1;
          pend_next = '0;
          mode_next = M_IDLE;
        end
        M_NLRUN: begin
          if (src_byte == "\n") begin
            if (line_next < LINE_LIMIT) line_next = line_next + 1'b1;
            consumed = 1'b1;
          end else begin
            mode_next = M_IDLE;
          end
        end
        M_COMMENT: begin
          if (src_byte == "\n") mode_next = M_IDLE;
          else consumed = 1'b1;
        end
        M_STRING, M_CSTRING: begin
          if (src_byte == "\"") begin
            res[n] = make_res((mode == M_STRING) ? K_STRING : K_CSTRING, ts, off,
                              ERR_NONE, line_next);
            n = n + 1'b1;
            mode_next = M_IDLE;
          end
          consumed = 1'b1;
        end
        M_AFTERC, M_IDENT: begin
          if (mode == M_AFTERC && src_byte == "\"") begin
            tstart_next = clamp(off1);
            mode_next   = M_CSTRING;
            consumed    = 1'b1;
          end else if (is_alpha(src_byte) || is_digit(src_byte)) begin
            for (int i = 0; i < KEYWORD_MAX_LEN; i++)
              if (klen_next == KLW'(i)) kbuf_next[8*i +: 8] = src_byte;
            if (klen_next <= KLW'(KEYWORD_MAX_LEN)) klen_next = klen_next + 1'b1;
            mode_next = M_IDENT;
            consumed  = 1'b1;
          end else begin
            kk = kw_match(64'(kbuf_next), 4'(klen_next));
            res[n] = make_res(kk, ts, off, ERR_NONE, line_next);
            n = n + 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_NUMBER: begin
          if (is_digit(src_byte)) begin
            consumed = 1'b1;
          end else if (src_byte == ".") begin
            consumed = 1'b1;
            if (seendec) begin
              res[n] = make_res(K_ERROR, off, off, ERR_DECIMAL, line_next);
              n = n + 1'b1;
              halted_next = 1'b1;
              mode_next   = M_IDLE;
            end else begin
              seendec_next = 1'b1;
            end
          end else begin
            res[n] = make_res(seendec ? K_DECIMAL : K_INT, ts, off, ERR_NONE, line_next);
            n = n + 1'b1;
            mode_next = M_IDLE;
          end
        end
        default: mode_next = M_IDLE;
      endcase

      if (!consumed && !halted_next) begin
        tstart_next = clamp(off);
        if (src_byte == " " || src_byte == "\r" || src_byte == "\t") begin
          // whitespace: nothing
        end else if (src_byte == "\n") begin
          if (line_next < LINE_LIMIT) line_next = line_next + 1'b1;
          res[n] = make_res(K_BREAK, {2'b00, clamp(off)}, off1, ERR_NONE, line_next);
          n = n + 1'b1;
          mode_next = M_NLRUN;
        end else if (src_byte == "\"") begin
          tstart_next = clamp(off1);
          mode_next   = M_STRING;
        end else if (src_byte == "!" || src_byte == "=" || src_byte == "<" ||
                     src_byte == ">") begin
          pend_next = src_byte;
          mode_next = M_PENDOP;
        end else if (sk != KIND_NONE) begin
          res[n] = make_res(sk[KIND_BITS-1:0], {2'b00, clamp(off)}, off1, ERR_NONE,
                            line_next);
          n = n + 1'b1;
        end else if (src_byte == "#") begin
          mode_next = M_COMMENT;
        end else if (is_alpha(src_byte)) begin
          kbuf_next = '0;
          kbuf_next[7:0] = src_byte;
          klen_next = KLW'(1);
          mode_next = (src_byte == "c") ? M_AFTERC : M_IDENT;
        end else if (is_digit(src_byte)) begin
          seendec_next = 1'b0;
          mode_next    = M_NUMBER;
        end else begin
          res[n] = make_res(K_ERROR, off, off, ERR_UNEXPECT, line_next);
          n = n + 1'b1;
          halted_next = 1'b1;
          mode_next   = M_IDLE;
        end
      end

      if (boff < OFF_LIMIT) boff_next = boff + 1'b1;

      if (eos) begin
        if (!halted_next) begin
          case (mode_next)
            M_PENDOP: begin
              res[n] = make_res(op_kind(pend_next, 1'b0), {2'b00, tstart_next},
                                {2'b00, tstart_next} + 1'b1, ERR_NONE, line_next);
              n = n + 1'b1;
            end
            M_STRING, M_CSTRING: begin
              res[n] = make_res(K_ERROR, off, off, ERR_UNTERM, line_next);
              n = n + 1'b1;
            end
            M_AFTERC, M_IDENT: begin
              kk = kw_match(64'(kbuf_next), 4'(klen_next));
              res[n] = make_res(kk, {2'b00, tstart_next}, {1'b0, boff_next},
                                ERR_NONE, line_next);
              n = n + 1'b1;
            end
            M_NUMBER: begin
              res[n] = make_res(seendec_next ? K_DECIMAL : K_INT, {2'b00, tstart_next},
                                {1'b0, boff_next}, ERR_NONE, line_next);
              n = n + 1'b1;
            end
            default: ;
          endcase
        end
        mode_next = M_IDLE; tstart_next = '0; boff_next = '0;
        line_next = LINE_BITS'(1); seendec_next = 1'b0; kbuf_next = '0;
        klen_next = '0; pend_next = '0; halted_next = 1'b0;
      end
    end
  end

  assign push      = acc && (n != '0);
  assign push_data = {res[2], res[1], res[0], n};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; tstart <= '0; boff <= '0; line <= LINE_BITS'(1);
      seendec <= 1'b0; kbuf <= '0; klen <= '0; pend <= '0; halted <= 1'b0;
    end else if (acc) begin
      mode <= mode_next; tstart <= tstart_next; boff <= boff_next;
      line <= line_next; seendec <= seendec_next; kbuf <= kbuf_next;
      klen <= klen_next; pend <= pend_next; halted <= halted_next;
    end
  end

endmodule

[hdl/slx_fifo.sv]
module slx_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         avail,
  output logic [W-1:0] rdata
);
  import slx_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [W-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign full  = count == (PW+1)'(QUEUE_DEPTH);
  assign avail = count != '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/slx_back.sv]
module slx_back #(
  parameter int RW  = 70,
  parameter int TDW = 72
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 avail,
  input  logic [slx_pkg::CNT_BITS+3*RW-1:0]    grp_in,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [TDW-1:0]                       m_tdata,
  output logic                                 m_tlast
);
  import slx_pkg::*;

  logic                              grp_valid;
  logic [CNT_BITS+3*RW-1:0]          grp;
  logic [CNT_BITS-1:0]               idx;
  logic [CNT_BITS-1:0]               cnt;
  logic                              load, last;
  logic [RW-1:0]                     cur;

  assign cnt  = grp[CNT_BITS-1:0];
  assign cur  = grp[CNT_BITS + RW*idx +: RW];
  assign last = idx == cnt - 1'b1;
  assign load = grp_valid && (!m_tvalid || m_tready);
  assign pop  = avail && (!grp_valid || (load && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (pop) begin
        grp_valid <= 1'b1;
        idx       <= '0;
      end else if (load) begin
        if (last) grp_valid <= 1'b0;
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) grp <= grp_in;
    if (load) begin
      m_tdata <= TDW'(cur);
      m_tlast <= last;
    end
  end

endmodule

[hdl/source_lexer.sv]
// channel  | dir | tdata (low bit up)                               | tlast
// s_axis   | in  | source_byte[7:0]                                 | end_of_source
// m_axis   | out | token_kind, lexeme_start, lexeme_length,         | last_of_run
//          |     | line_number, error_code, zero pad to bytes        |
// One source byte per cycle is scanned while s_tready is high; each byte
// yields zero to three tokens. Tokens leave one per cycle through the output
// register while m_tready is high, so bursts of several tokens per byte are
// absorbed by a four-entry group queue. s_tready drops only when that queue is
// full. rst is synchronous and returns the scanner to line 1, offset 0.
module source_lexer #(
  parameter int OFFSET_BITS     = slx_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = slx_pkg::KEYWORD_MAX_LEN_DEF,
  localparam int RW  = slx_pkg::KIND_BITS + 2 * OFFSET_BITS + 1 + slx_pkg::LINE_BITS
                       + slx_pkg::ERR_BITS,
  localparam int TDW = ((RW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,   // source_byte
  input  logic           s_tlast,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [TDW-1:0] m_tdata,   // token_kind, lexeme_start, lexeme_length,
                                    // line_number, error_code
  output logic           m_tlast
);
  import slx_pkg::*;

  localparam int GW = CNT_BITS + 3 * RW;

  logic          full, push, pop, avail, acc;
  logic [GW-1:0] wdata, rdata;

  assign s_tready = !full;
  assign acc      = s_tvalid && s_tready;

  slx_front #(
    .OFFSET_BITS(OFFSET_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN), .RW(RW)
  ) u_front (
    .clk(clk), .rst(rst), .acc(acc), .src_byte(s_tdata), .eos(s_tlast),
    .push(push), .push_data(wdata)
  );

  slx_fifo #(.W(GW)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(wdata), .full(full),
    .pop(pop), .avail(avail), .rdata(rdata)
  );

  slx_back #(.RW(RW), .TDW(TDW)) u_back (
    .clk(clk), .rst(rst), .avail(avail), .grp_in(rdata), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule
